// ===== hdl/rce_pkg.sv =====
// Shared types and constants for the RIFF chunk extractor.
package rce_pkg;

	// Input transaction: one stream byte or an end marker
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	// Output transaction: a payload byte or a final status
	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last_of_chunk;
	} out_item_t;

	// Configuration registers as seen by the parser
	typedef struct packed {
		logic [31:0] form_type;
		logic [31:0] wanted_chunk_type;
	} cfg_t;

	// Parser phases
	typedef enum logic [1:0] {
		PH_FILE_HDR,
		PH_CHUNK_HDR,
		PH_BODY,
		PH_HALT
	} phase_t;

	// Status codes
	localparam logic [2:0] ST_PAYLOAD    = 3'd0;
	localparam logic [2:0] ST_NOT_RIFF   = 3'd1;
	localparam logic [2:0] ST_WRONG_FORM = 3'd2;
	localparam logic [2:0] ST_TRUNCATED  = 3'd3;
	localparam logic [2:0] ST_CLEAN_END  = 3'd4;

	// Register indexes
	localparam logic CFG_FORM_TYPE    = 1'b0;
	localparam logic CFG_WANTED_CHUNK = 1'b1;

	// Four-character codes, first byte in the low bits
	localparam logic [31:0] MAGIC_RIFF  = 32'h4646_4952;
	localparam logic [31:0] FOURCC_H264 = 32'h3436_3268;

	// Replace one byte lane of a 32-bit word
	function automatic logic [31:0] set_byte(input logic [31:0] word,
						 input logic [1:0] lane,
						 input logic [7:0] b);
		logic [31:0] w;
		w = word;
		case (lane)
			2'd0: w[7:0]   = b;
			2'd1: w[15:8]  = b;
			2'd2: w[23:16] = b;
			2'd3: w[31:24] = b;
			default: w = word;
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/rce_parser.sv =====
// Parser state and per-byte update for the RIFF chunk extractor.
module rce_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  rce_pkg::in_item_t item,
	input  rce_pkg::cfg_t     cfg,
	output logic              res_valid,
	output rce_pkg::out_item_t res
);
	import rce_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  hidx_q, hidx_n;
	logic [31:0] hword_q, hword_n;
	logic [31:0] ctype_q, ctype_n;
	logic [31:0] pleft_q, pleft_n;
	logic [32:0] aleft_q, aleft_n;
	logic        sel_q, sel_n;

	// Next state and result for the transaction in the input register
	always_comb begin
		phase_n   = phase_q;
		hidx_n    = hidx_q;
		hword_n   = hword_q;
		ctype_n   = ctype_q;
		pleft_n   = pleft_q;
		aleft_n   = aleft_q;
		sel_n     = sel_q;
		res_valid = 1'b0;
		res       = '0;
		if (fire && phase_q != PH_HALT) begin
			if (item.end_of_stream) begin
				// clean only at a chunk boundary
				res_valid = 1'b1;
				res.status = (phase_q == PH_CHUNK_HDR && hidx_q == 4'd0) ?
					     ST_CLEAN_END : ST_TRUNCATED;
				phase_n = PH_HALT;
			end else begin
				case (phase_q)
					PH_FILE_HDR: begin
						if (hidx_q < 4'd4)
							ctype_n = set_byte(ctype_q, hidx_q[1:0], item.data_byte);
						else if (hidx_q >= 4'd8)
							hword_n = set_byte(hword_q, hidx_q[1:0], item.data_byte);
						if (hidx_q >= 4'd11) begin
							if (ctype_n != MAGIC_RIFF) begin
								res_valid  = 1'b1;
								res.status = ST_NOT_RIFF;
								phase_n    = PH_HALT;
							end else if (hword_n != cfg.form_type) begin
								res_valid  = 1'b1;
								res.status = ST_WRONG_FORM;
								phase_n    = PH_HALT;
							end else begin
								phase_n = PH_CHUNK_HDR;
								hidx_n  = 4'd0;
								hword_n = '0;
								ctype_n = '0;
							end
						end else begin
							hidx_n = hidx_q + 4'd1;
						end
					end
					PH_CHUNK_HDR: begin
						// fourcc in bytes 0..3, size in bytes 4..7
						if (!hidx_q[2])
							ctype_n = set_byte(ctype_q, hidx_q[1:0], item.data_byte);
						else
							hword_n = set_byte(hword_q, hidx_q[1:0], item.data_byte);
						if (hidx_q[2:0] == 3'd7) begin
							pleft_n = hword_n;
							aleft_n = ({1'b0, hword_n} + 33'd3) & ~33'd3;
							sel_n   = (ctype_n == cfg.wanted_chunk_type);
							hidx_n  = 4'd0;
							if (aleft_n != '0)
								phase_n = PH_BODY;
						end else begin
							hidx_n = {1'b0, hidx_q[2:0] + 3'd1};
						end
					end
					PH_BODY: begin
						if (aleft_q != '0)
							aleft_n = aleft_q - 33'd1;
						if (pleft_q != '0) begin
							pleft_n = pleft_q - 32'd1;
							if (sel_q) begin
								res_valid         = 1'b1;
								res.out_byte      = item.data_byte;
								res.status        = ST_PAYLOAD;
								res.last_of_chunk = (pleft_q == 32'd1);
							end
						end
						// padding done, next chunk header
						if (aleft_n == '0) begin
							phase_n = PH_CHUNK_HDR;
							hidx_n  = 4'd0;
						end
					end
					default: phase_n = phase_q;
				endcase
			end
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FILE_HDR;
			hidx_q  <= '0;
			hword_q <= '0;
			ctype_q <= '0;
			pleft_q <= '0;
			aleft_q <= '0;
			sel_q   <= 1'b0;
		end else begin
			phase_q <= phase_n;
			hidx_q  <= hidx_n;
			hword_q <= hword_n;
			ctype_q <= ctype_n;
			pleft_q <= pleft_n;
			aleft_q <= aleft_n;
			sel_q   <= sel_n;
		end
	end

endmodule

// ===== hdl/riff_chunk_extractor.sv =====
// Top level of the RIFF chunk extractor: input register, parser, result register.
//
// Input channel (in_valid / in_stall / in_item) carries one RIFF stream byte
// per transaction, or an end marker. Output channel (out_valid / out_stall /
// out_item) carries forwarded payload bytes of chunks whose fourcc equals
// wanted_chunk_type, then one status transaction on error or clean end.
// Bytes that yield nothing (headers, padding, other chunks) are consumed
// silently.
// Results go from the input register through the parser to the result register.
// Throughput: one byte per cycle while no stalled result is held; each byte is a
// counter and compare update between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// takes one more transaction, after which in_stall is raised.
// After a status result the block ignores all input until reset.
// Reset (arst_n low) clears the pipeline and the parser and loads both
// configuration registers with "h264". Write configuration through
// cfg_we / cfg_index / cfg_wdata only while the block is idle.
module riff_chunk_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rce_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output rce_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata
);
	import rce_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;
	logic      adv;
	logic      res_valid;
	out_item_t res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.form_type         <= FOURCC_H264;
			cfg_q.wanted_chunk_type <= FOURCC_H264;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORM_TYPE:    cfg_q.form_type         <= cfg_wdata;
				CFG_WANTED_CHUNK: cfg_q.wanted_chunk_type <= cfg_wdata;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// Stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_item;
	end

	rce_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid)
			item_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// ===== hdl/rce_checker.sv =====
// Port-level assertions for the RIFF chunk extractor, bound to the top level.
module rce_port_checks (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input rce_pkg::out_item_t out_item
);
	import rce_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// Only defined status codes appear
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status <= ST_CLEAN_END)
		else $error("undefined status code");

	// Status transactions carry no byte and no chunk end flag
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != ST_PAYLOAD |->
		out_item.out_byte == 8'd0 && !out_item.last_of_chunk)
		else $error("status result with payload fields set");

	// Nothing follows a delivered status
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.status != ST_PAYLOAD |=> !out_valid)
		else $error("result after halting status");

endmodule

bind riff_chunk_extractor rce_port_checks u_rce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

// ===== tb/rce_checker.sv =====
// Checker for the RIFF chunk extractor: predicts results from watched transactions and compares.
`timescale 1ns / 1ps

module rce_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  rce_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_stall,
	input  rce_pkg::out_item_t out_item,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata,
	output int                 errors,
	output int                 pending,
	output int                 results
);
	import rce_pkg::*;

	// Shadow copy of the configuration registers
	logic [31:0] form_fourcc;
	logic [31:0] wanted_fourcc;

	// Shadow copy of the parser state
	phase_t      ph;
	logic [3:0]  hdr_idx;
	logic [31:0] hdr_word;
	logic [31:0] fourcc_seen;
	logic [31:0] payload_left;
	logic [32:0] body_left;
	logic        selected;

	out_item_t   due_results[$];
	int          mismatch_count;
	int          result_count;

	// Halt with a status transaction
	task automatic emit_status(input logic [2:0] code);
		out_item_t r;
		r.out_byte      = 8'd0;
		r.status        = code;
		r.last_of_chunk = 1'b0;
		due_results.push_back(r);
		ph = PH_HALT;
	endtask

	// Advance the parser by one input transaction and queue what it yields
	task automatic parse_byte(input in_item_t it);
		out_item_t   r;
		int          i;
		logic [31:0] b;
		b = {24'd0, it.data_byte};
		if (ph == PH_HALT)
			return;
		if (it.end_of_stream) begin
			if (ph == PH_CHUNK_HDR && hdr_idx == 4'd0)
				emit_status(ST_CLEAN_END);
			else
				emit_status(ST_TRUNCATED);
			return;
		end
		case (ph)
			PH_FILE_HDR: begin
				i = int'(hdr_idx);
				if (i < 4)
					fourcc_seen = fourcc_seen | (b << (8 * i));
				else if (i >= 8 && i < 12)
					hdr_word = hdr_word | (b << (8 * (i - 8)));
				if (i >= 11) begin
					// magic is checked before the form type
					if (fourcc_seen != MAGIC_RIFF)
						emit_status(ST_NOT_RIFF);
					else if (hdr_word != form_fourcc)
						emit_status(ST_WRONG_FORM);
					else begin
						ph          = PH_CHUNK_HDR;
						hdr_idx     = 4'd0;
						hdr_word    = 32'd0;
						fourcc_seen = 32'd0;
					end
				end else begin
					hdr_idx = hdr_idx + 4'd1;
				end
			end
			PH_CHUNK_HDR: begin
				i = int'(hdr_idx[2:0]);
				if (i < 4)
					fourcc_seen = (i == 0 ? 32'd0 : fourcc_seen) | (b << (8 * i));
				else
					hdr_word = (i == 4 ? 32'd0 : hdr_word) | (b << (8 * (i - 4)));
				if (i == 7) begin
					payload_left = hdr_word;
					body_left    = ({1'b0, hdr_word} + 33'd3) & ~33'd3;
					selected     = (fourcc_seen == wanted_fourcc);
					hdr_idx      = 4'd0;
					// a zero-size chunk has no body
					if (body_left != 33'd0)
						ph = PH_BODY;
				end else begin
					hdr_idx = 4'(i + 1);
				end
			end
			PH_BODY: begin
				if (body_left != 33'd0)
					body_left = body_left - 33'd1;
				if (payload_left != 32'd0) begin
					payload_left = payload_left - 32'd1;
					if (selected) begin
						r.out_byte      = it.data_byte;
						r.status        = ST_PAYLOAD;
						r.last_of_chunk = (payload_left == 32'd0);
						due_results.push_back(r);
					end
				end
				if (body_left == 33'd0) begin
					ph      = PH_CHUNK_HDR;
					hdr_idx = 4'd0;
				end
			end
			default: ;
		endcase
	endtask

	// Watch all three ports at each edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			form_fourcc    = FOURCC_H264;
			wanted_fourcc  = FOURCC_H264;
			ph             = PH_FILE_HDR;
			hdr_idx        = 4'd0;
			hdr_word       = 32'd0;
			fourcc_seen    = 32'd0;
			payload_left   = 32'd0;
			body_left      = 33'd0;
			selected       = 1'b0;
			mismatch_count = 0;
			result_count   = 0;
			due_results.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FORM_TYPE)
					form_fourcc = cfg_wdata;
				else
					wanted_fourcc = cfg_wdata;
			end
			// input transaction
			if (in_valid && !in_stall)
				parse_byte(in_item);
			// output transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				result_count++;
				if (due_results.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: unexpected result byte=%02h status=%0d last=%0b",
							$realtime, out_item.out_byte, out_item.status,
							out_item.last_of_chunk);
					mismatch_count++;
				end else begin
					want = due_results.pop_front();
					if (out_item.out_byte !== want.out_byte ||
					    out_item.status !== want.status ||
					    out_item.last_of_chunk !== want.last_of_chunk) begin
						if (mismatch_count < 10)
							$display({"%0t: mismatch byte %02h/%02h status %0d/%0d ",
								"last %0b/%0b (exp/got)"},
								$realtime, want.out_byte, out_item.out_byte,
								want.status, out_item.status,
								want.last_of_chunk, out_item.last_of_chunk);
						mismatch_count++;
					end
				end
			end
		end
		errors  <= mismatch_count;
		pending <= due_results.size();
		results <= result_count;
	end

endmodule

// ===== tb/tb_riff_chunk_extractor.sv =====
// Testbench top for the RIFF chunk extractor: stream stimulus, handshake pressure, verdict.
`timescale 1ns / 1ps

module tb_riff_chunk_extractor;
	import rce_pkg::*;

	localparam int CYCLE_LIMIT = 200_000;
	localparam int PHASE_ITEMS = 250;

	// How the stream is finished
	typedef enum int {
		END_CLEAN,
		END_IN_HEADER,
		END_IN_HUGE_BODY,
		END_IN_PADDING
	} end_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_FORM_TYPE;
	logic [31:0] cfg_wdata = 32'd0;

	int          errors;
	int          pending;
	int          results;
	int          idle_pct = 0;
	int          stall_pct = 0;
	int          items_sent = 0;
	int          chunks_sent = 0;
	int          cycle_count = 0;
	logic [31:0] cur_wanted = FOURCC_H264;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	riff_chunk_extractor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	rce_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.results   (results)
	);

	// Receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Cycle counter and watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
		$display("Simulation FAILED");
		$finish;
	end

	// One input transaction, with an optional idle gap in front
	task automatic send_item(input in_item_t it);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		it.data_byte     = b;
		it.end_of_stream = 1'b0;
		send_item(it);
	endtask

	// End marker; the byte lane carries junk
	task automatic send_end();
		in_item_t it;
		it.data_byte     = 8'($urandom);
		it.end_of_stream = 1'b1;
		send_item(it);
	endtask

	// Little-endian word, first byte in the low bits
	task automatic send_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			send_byte(w[8 * k +: 8]);
	endtask

	// Chunk header plus body_bytes of random body
	task automatic send_chunk(input logic [31:0] fourcc, input logic [31:0] size,
				  input int body_bytes);
		send_word(fourcc);
		send_word(size);
		repeat (body_bytes)
			send_byte(8'($urandom));
		chunks_sent++;
	endtask

	// Random well-formed chunk: half wanted, the rest near misses and strangers
	task automatic send_random_chunk();
		logic [31:0] fourcc;
		int          size;
		int          pick;
		pick = $urandom_range(9);
		if (pick < 5)
			fourcc = cur_wanted;
		else if (pick < 7)
			fourcc = $urandom;
		else if (pick < 9)
			fourcc = cur_wanted ^ (32'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
		else
			fourcc = cur_wanted ^ (32'd1 << $urandom_range(31));
		pick = $urandom_range(99);
		if (pick < 60)
			size = $urandom_range(0, 8);
		else if (pick < 95)
			size = $urandom_range(9, 32);
		else
			size = $urandom_range(33, 96);
		send_chunk(fourcc, 32'(size), (size + 3) & ~3);
	endtask

	task automatic write_cfg(input logic idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Let every due result arrive, then cover the pipeline latency
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int          idle_tab[4];
		int          stall_tab[4];
		logic [31:0] form;
		end_kind_t   end_kind;

		idle_tab  = '{0, 78, 0, 20};
		stall_tab = '{0, 0, 78, 20};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// form type: either the reset value or a fresh random one
		form = $urandom_range(1) ? FOURCC_H264 : $urandom;
		write_cfg(CFG_FORM_TYPE, form);

		// Directed: file header, empty chunk, short wanted chunk with padding, padded unwanted chunk
		send_word(MAGIC_RIFF);
		send_word($urandom);
		send_word(form);
		send_chunk(cur_wanted, 32'd0, 0);
		send_chunk(cur_wanted, 32'd2, 0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_chunk(32'h0000_0000, 32'd3, 4);

		// Random chunks under four handshake settings
		for (int p = 0; p < 4; p++) begin
			if (p > 0) begin
				drain();
				case (p)
					1: begin
						cur_wanted = 32'h0000_0000;
						write_cfg(CFG_FORM_TYPE, 32'h0000_0000);
					end
					2: begin
						cur_wanted = 32'hFFFF_FFFF;
						write_cfg(CFG_FORM_TYPE, 32'hFFFF_FFFF);
					end
					default: cur_wanted = $urandom;
				endcase
				write_cfg(CFG_WANTED_CHUNK, cur_wanted);
			end
			idle_pct  = idle_tab[p];
			stall_pct = stall_tab[p];
			while (items_sent < 32 + (p + 1) * PHASE_ITEMS)
				send_random_chunk();
		end

		// Finish the stream, cleanly or broken
		end_kind = end_kind_t'($urandom_range(3));
		case (end_kind)
			END_IN_HEADER:
				repeat ($urandom_range(1, 7))
					send_byte(8'($urandom));
			END_IN_HUGE_BODY:
				send_chunk(cur_wanted,
					$urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000),
					$urandom_range(1, 6));
			END_IN_PADDING:
				send_chunk(cur_wanted, 32'd5, 6);
			default: ;
		endcase
		send_end();

		// Halted block must swallow everything after the status
		repeat (16) begin
			in_item_t junk;
			junk.data_byte     = 8'($urandom);
			junk.end_of_stream = 1'($urandom);
			send_item(junk);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);

		$display("Stream of %0d transactions in %0d chunks, four wanted types and four pressure settings, ended by %s.",
			items_sent, chunks_sent, end_kind.name());
		$display("%0d results checked, %0d mismatches.", results, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
